>>> src/decimal32_to_text_unit_defines.svh
// Assertion macros for the decimal32 to text unit.
// Used by the datapath; no other dependencies.
`ifndef DECIMAL32_TO_TEXT_UNIT_DEFINES_SVH
`define DECIMAL32_TO_TEXT_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

`define D32_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed");

`define D32_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define D32_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define D32_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define D32_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define D32_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> src/d32txt_pkg.sv
// Shared types, constants and the declet decoder of the decimal32 to text unit.
// No dependencies.
`default_nettype none

package d32txt_pkg;

    localparam int DEFAULT_MAX_TEXT = 64;
    localparam int NUM_DIGITS       = 7;

    localparam logic [1:0] CFG_IDX_ENCODING  = 2'd0;
    localparam logic [1:0] CFG_IDX_MAX_CHARS = 2'd1;

    localparam logic       ENC_BID         = 1'b0;
    localparam logic       ENC_DPD         = 1'b1;
    localparam logic [6:0] MAX_CHARS_RESET = 7'd64;

    localparam logic [7:0]  EXP_BIAS     = 8'd101;
    localparam logic [31:0] STEER_MASK   = 32'h6000_0000;
    localparam logic [31:0] BID_LONG_MSK = 32'h001f_ffff;
    localparam logic [31:0] BID_SHRT_MSK = 32'h007f_ffff;
    localparam logic [31:0] DPD_DEC_MSK  = 32'h000f_ffff;
    localparam logic [4:0]  G_LARGE      = 5'b11000;
    localparam logic [23:0] BID_MAX      = 24'd9999999;
    localparam logic [31:0] BID_RECIP    = 32'hCCCC_CCCD;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef struct packed {
        logic load;
        logic step;
        logic prep1;
        logic prep2;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_dpd;
        logic dig_done;
        logic cnt_zero;
        logic cnt_one;
        logic out_free;
    } t_dp_status;

    function automatic logic [11:0] declet_to_bcd(input logic [9:0] d);
        logic [3:0] d2;
        logic [3:0] d1;
        logic [3:0] d0;
        d2 = {1'b0, d[9:7]};
        d1 = {1'b0, d[6:4]};
        d0 = {1'b0, d[2:0]};
        if (d[3]) begin
            unique case (d[3:1])
                3'b100: begin
                    d0 = {3'b100, d[0]};
                end
                3'b101: begin
                    d1 = {3'b100, d[4]};
                    d0 = {1'b0, d[6], d[5], d[0]};
                end
                3'b110: begin
                    d2 = {3'b100, d[7]};
                    d0 = {1'b0, d[9], d[8], d[0]};
                end
                default: begin
                    unique case (d[6:5])
                        2'b10: begin
                            d1 = {3'b100, d[4]};
                            d0 = {3'b100, d[0]};
                        end
                        2'b01: begin
                            d2 = {3'b100, d[7]};
                            d1 = {1'b0, d[9], d[8], d[4]};
                            d0 = {3'b100, d[0]};
                        end
                        2'b00: begin
                            d2 = {3'b100, d[7]};
                            d1 = {3'b100, d[4]};
                            d0 = {1'b0, d[9], d[8], d[0]};
                        end
                        default: begin
                            d2 = {3'b100, d[7]};
                            d1 = {3'b100, d[4]};
                            d0 = {3'b100, d[0]};
                        end
                    endcase
                end
            endcase
        end
        return {d2, d1, d0};
    endfunction

endpackage

`default_nettype wire

>>> src/decimal32_to_text_unit.sv
// Top level of the decimal32 to text unit: controller plus datapath.
// Depends on d32txt_pkg, d32txt_ctrl and d32txt_dp.
//
//   channel  signals                                   direction
//   in       i_in_valid, o_in_ready, i_word            sink
//   out      o_out_valid, i_out_ready, o_text_char,    source
//            o_last
//   cfg      i_cfg_valid, o_cfg_ready, i_cfg_index,    sink
//            i_cfg_data
//
// BID converts the coefficient to BCD in the divide-by-ten unit, one digit a cycle.
// Output runs one character a cycle, while the receiver is ready, through a single output register.
// A stall on the output holds the current character and the sequencer.
// Reset is synchronous, active low; the config port is always ready.
`default_nettype none

module decimal32_to_text_unit
    import d32txt_pkg::*;
#(
    parameter int MAX_TEXT = DEFAULT_MAX_TEXT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_word,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_text_char,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [6:0]  i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    d32txt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    d32txt_dp #(
        .MAX_TEXT (MAX_TEXT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (i_word),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_text_char (o_text_char),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

>>> src/d32txt_ctrl.sv
// Controller of the decimal32 to text unit: sequences load, digit conversion,
// length setup and character output. Depends on d32txt_pkg.
`default_nettype none

module d32txt_ctrl
    import d32txt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_PREP1,
        S_PREP2,
        S_EMIT
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_in_ready;
    logic    n_in_ready;
    t_dp_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    cmd.load = 1'b1;
                    n_state  = i_status.is_dpd ? S_PREP1 : S_CONV;
                end
            end
            S_CONV: begin
                cmd.step = 1'b1;
                if (i_status.dig_done) begin
                    n_state = S_PREP1;
                end
            end
            S_PREP1: begin
                cmd.prep1 = 1'b1;
                n_state   = S_PREP2;
            end
            S_PREP2: begin
                cmd.prep2 = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.cnt_zero) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    cmd.emit = 1'b1;
                    if (i_status.cnt_one) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_in_ready = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_in_ready;
        end
    end

    assign o_in_ready = r_in_ready;
    assign o_cmd      = cmd;

endmodule

`default_nettype wire

>>> src/d32txt_dp.sv
// Datapath of the decimal32 to text unit: registers, field decode, BCD
// conversion, string lengths and output register. Depends on d32txt_pkg.
`default_nettype none
`include "decimal32_to_text_unit_defines.svh"

module d32txt_dp
    import d32txt_pkg::*;
#(
    parameter int MAX_TEXT = DEFAULT_MAX_TEXT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [31:0] i_word,
    input  wire logic        i_cfg_valid,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [6:0]  i_cfg_data,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_status       o_status,
    input  wire logic        i_out_ready,
    output logic             o_out_valid,
    output logic [7:0]       o_text_char,
    output logic             o_last
);

    localparam int CW = $clog2(MAX_TEXT + 1);

    logic        r_encoding;
    logic [6:0]  r_max_chars;

    logic        r_sign;
    logic [7:0]  r_exp;
    logic [23:0] r_bin;
    logic [27:0] r_mant;
    logic [2:0]  r_dig_cnt;

    logic [6:0]  r_frac;
    logic        r_neg;
    logic [2:0]  r_int_len;
    logic [7:0]  r_zero_end;
    logic [7:0]  r_int_off;
    logic [7:0]  r_int_end;
    logic [CW-1:0] r_cnt;

    logic        r_out_valid;
    logic [7:0]  r_char;
    logic        r_last;

    // field decode
    logic        steer_long;
    logic [23:0] bid_coef;
    logic [7:0]  bid_exp;
    logic [4:0]  dpd_g;
    logic [1:0]  dpd_msb;
    logic [3:0]  dpd_lead;
    logic [7:0]  dpd_exp;
    logic [27:0] dpd_mant;

    always_comb begin
        steer_long = ((i_word & STEER_MASK) == STEER_MASK);
        if (steer_long) begin
            bid_coef = {3'b100, i_word[20:0]} | 24'(i_word & BID_LONG_MSK);
            bid_exp  = i_word[28:21];
        end else begin
            bid_coef = 24'(i_word & BID_SHRT_MSK);
            bid_exp  = i_word[30:23];
        end
        if (bid_coef > BID_MAX) begin
            bid_coef = '0;
        end
        dpd_g = i_word[30:26];
        if ((dpd_g & G_LARGE) == G_LARGE) begin
            dpd_msb  = dpd_g[2:1];
            dpd_lead = {3'b100, dpd_g[0]};
        end else begin
            dpd_msb  = dpd_g[4:3];
            dpd_lead = {1'b0, dpd_g[2:0]};
        end
        dpd_exp  = {dpd_msb, i_word[25:20]};
        dpd_mant = {dpd_lead, declet_to_bcd(i_word[19:10]),
                    declet_to_bcd(10'(i_word & DPD_DEC_MSK))};
    end

    // one decimal digit per step by reciprocal multiply
    logic [55:0] bin_prod;
    logic [20:0] bin_quot;
    logic [23:0] bin_rem;

    assign bin_prod = 56'(r_bin) * 56'(BID_RECIP);
    assign bin_quot = bin_prod[55:35];
    assign bin_rem  = r_bin - ({bin_quot, 3'b000} + {2'b00, bin_quot, 1'b0});

    // length setup
    logic       exp_neg;
    logic [6:0] frac_n;
    logic [7:0] zero_n;
    logic [2:0] sig_dig;
    logic [2:0] int_len;
    logic [7:0] total_len;
    logic [7:0] cap;
    logic [7:0] emit_n;

    always_comb begin
        exp_neg = (r_exp < EXP_BIAS);
        frac_n  = exp_neg ? 7'(EXP_BIAS - r_exp) : 7'd0;
        zero_n  = exp_neg ? 8'd0 : (r_exp - EXP_BIAS);
        sig_dig = '0;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (r_mant[4*k +: 4] != 4'd0) begin
                sig_dig = 3'(k + 1);
            end
        end
        int_len = ({4'd0, sig_dig} > frac_n) ? 3'(7'(sig_dig) - frac_n) : 3'd1;
        total_len = r_zero_end + {5'd0, r_int_len} + {7'd0, r_neg};
        cap = (r_max_chars > 7'(MAX_TEXT)) && (MAX_TEXT < 128) ? 8'(MAX_TEXT)
                                                                : {1'b0, r_max_chars};
        emit_n = (total_len < cap) ? total_len : cap;
    end

    // character at low-order position r_cnt - 1
    logic [CW-1:0] j_idx;
    logic [7:0]    j_pos;
    logic [7:0]    nib_idx;
    logic [3:0]    digit;
    logic [7:0]    next_char;

    always_comb begin
        j_idx   = r_cnt - CW'(1);
        j_pos   = 8'(j_idx);
        nib_idx = (j_pos < {1'b0, r_frac}) ? j_pos : (j_pos - r_int_off);
        digit   = (nib_idx < 8'(NUM_DIGITS)) ? 4'(r_mant >> {nib_idx[2:0], 2'b00}) : 4'd0;
        if (j_pos < {1'b0, r_frac}) begin
            next_char = CHAR_ZERO + {4'd0, digit};
        end else if ((r_frac != 7'd0) && (j_pos == {1'b0, r_frac})) begin
            next_char = CHAR_DOT;
        end else if (j_pos < r_zero_end) begin
            next_char = CHAR_ZERO;
        end else if (j_pos < r_int_end) begin
            next_char = CHAR_ZERO + {4'd0, digit};
        end else begin
            next_char = CHAR_MINUS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_encoding  <= ENC_BID;
            r_max_chars <= MAX_CHARS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IDX_ENCODING:  r_encoding  <= i_cfg_data[0];
                CFG_IDX_MAX_CHARS: r_max_chars <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sign    <= i_word[31];
            r_dig_cnt <= '0;
            if (r_encoding == ENC_DPD) begin
                r_exp  <= dpd_exp;
                r_mant <= dpd_mant;
            end else begin
                r_exp <= bid_exp;
                r_bin <= bid_coef;
            end
        end else if (i_cmd.step) begin
            r_bin     <= {3'b000, bin_quot};
            r_mant    <= {bin_rem[3:0], r_mant[27:4]};
            r_dig_cnt <= r_dig_cnt + 3'd1;
        end
        if (i_cmd.prep1) begin
            r_frac     <= frac_n;
            r_neg      <= r_sign && (r_mant != 28'd0);
            r_int_len  <= int_len;
            r_zero_end <= exp_neg ? ({1'b0, frac_n} + 8'd1) : zero_n;
            r_int_off  <= exp_neg ? 8'd1 : zero_n;
        end
        if (i_cmd.prep2) begin
            r_int_end <= r_zero_end + {5'd0, r_int_len};
        end
        if (i_cmd.emit) begin
            r_char <= next_char;
            r_last <= (r_cnt == CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.prep1) begin
                r_cnt <= '0;
            end else if (i_cmd.prep2) begin
                r_cnt <= CW'(emit_n);
            end else if (i_cmd.emit) begin
                r_cnt <= r_cnt - CW'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.is_dpd   = (r_encoding == ENC_DPD);
        o_status.dig_done = (r_dig_cnt == 3'(NUM_DIGITS - 1));
        o_status.cnt_zero = (r_cnt == '0);
        o_status.cnt_one  = (r_cnt == CW'(1));
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_text_char = r_char;
    assign o_last      = r_last;

    `D32_ASSERT_IMPLY(a_emit_free, i_clk, i_rst_n, i_cmd.emit, !r_out_valid || i_out_ready)
    `D32_ASSERT_NEXT(a_last_char, i_clk, i_rst_n, i_cmd.emit && r_cnt == CW'(1), r_out_valid && r_last)
    `D32_ASSERT_ALWAYS(a_cnt_cap, i_clk, i_rst_n, r_cnt <= CW'(MAX_TEXT))
    `D32_ASSERT_IMPLY(a_bin_range, i_clk, i_rst_n, i_cmd.step, r_bin <= BID_MAX)

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for decimal32_to_text_unit: directed and random decimal32 words in
// both coefficient encodings, each output character checked against a local text predictor.
// Depends on d32txt_pkg and the unit's RTL.

module testbench
    import d32txt_pkg::*;
();

    localparam int         WATCHDOG_LIMIT = 3000;
    localparam int         SETTLE_CYCLES  = 40;
    localparam logic [1:0] CFG_IDX_SPARE  = 2'd3;

    typedef struct {
        logic [31:0] word;
        bit          drain;
    } word_item_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_word      = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_text_char;
    logic        o_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [6:0]  i_cfg_data  = '0;

    word_item_t  word_queue[$];
    text_char_t  pending_text[$];
    logic        cur_encoding   = ENC_BID;
    logic [6:0]  cur_max_chars  = MAX_CHARS_RESET;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          error_count    = 0;
    int          quiet_cycles   = 0;

    decimal32_to_text_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_word      (i_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_text_char (o_text_char),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    function automatic logic [11:0] declet_digits(input logic [9:0] d);
        logic [3:0] hi;
        logic [3:0] mid;
        logic [3:0] lo;
        hi  = {1'b0, d[9:7]};
        mid = {1'b0, d[6:4]};
        lo  = {1'b0, d[2:0]};
        if (d[3]) begin
            case (d[2:1])
                2'b00: begin
                    lo = {3'b100, d[0]};
                end
                2'b01: begin
                    mid = {3'b100, d[4]};
                    lo  = {1'b0, d[6:5], d[0]};
                end
                2'b10: begin
                    hi = {3'b100, d[7]};
                    lo = {1'b0, d[9:8], d[0]};
                end
                default: begin
                    case (d[6:5])
                        2'b10: begin
                            mid = {3'b100, d[4]};
                            lo  = {3'b100, d[0]};
                        end
                        2'b01: begin
                            hi  = {3'b100, d[7]};
                            mid = {1'b0, d[9:8], d[4]};
                            lo  = {3'b100, d[0]};
                        end
                        2'b00: begin
                            hi  = {3'b100, d[7]};
                            mid = {3'b100, d[4]};
                            lo  = {1'b0, d[9:8], d[0]};
                        end
                        default: begin
                            hi  = {3'b100, d[7]};
                            mid = {3'b100, d[4]};
                            lo  = {3'b100, d[0]};
                        end
                    endcase
                end
            endcase
        end
        return {hi, mid, lo};
    endfunction

    function automatic void split_word(input logic [31:0] w, input logic enc,
                                       output logic [27:0] bcd, output logic [7:0] bexp);
        logic [4:0]  g;
        logic [1:0]  top;
        logic [3:0]  lead;
        logic [23:0] coeff;
        int unsigned rest;
        if (enc == ENC_DPD) begin
            g = w[30:26];
            if (g[4:3] == 2'b11) begin
                top  = g[2:1];
                lead = {3'b100, g[0]};
            end else begin
                top  = g[4:3];
                lead = {1'b0, g[2:0]};
            end
            bexp = {top, w[25:20]};
            bcd  = {lead, declet_digits(w[19:10]), declet_digits(w[9:0])};
        end else begin
            if (w[30:29] == 2'b11) begin
                coeff = {3'b100, w[20:0]};
                bexp  = w[28:21];
            end else begin
                coeff = {1'b0, w[22:0]};
                bexp  = w[30:23];
            end
            rest = (coeff > BID_MAX) ? 0 : coeff;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                bcd[4*i +: 4] = 4'(rest % 10);
                rest = rest / 10;
            end
        end
    endfunction

    function automatic void render_text(input logic [31:0] w);
        logic [27:0] mant;
        logic [7:0]  bexp;
        logic [7:0]  chars[$];
        int          e;
        int          cap;
        bit          neg;
        text_char_t  tc;
        split_word(w, cur_encoding, mant, bexp);
        cap = (cur_max_chars > DEFAULT_MAX_TEXT) ? DEFAULT_MAX_TEXT : cur_max_chars;
        e   = int'(bexp) - int'(EXP_BIAS);
        neg = w[31] && (mant != 0);
        while (e < 0 && chars.size() < cap) begin
            chars.push_back(CHAR_ZERO + mant[3:0]);
            mant = mant >> 4;
            e++;
        end
        if (chars.size() > 0 && chars.size() < cap) begin
            chars.push_back(CHAR_DOT);
        end
        while (e > 0 && chars.size() < cap) begin
            chars.push_back(CHAR_ZERO);
            e--;
        end
        if (mant != 0) begin
            while (mant != 0 && chars.size() < cap) begin
                chars.push_back(CHAR_ZERO + mant[3:0]);
                mant = mant >> 4;
            end
        end else if (chars.size() < cap) begin
            chars.push_back(CHAR_ZERO);
        end
        if (neg && chars.size() < cap) begin
            chars.push_back(CHAR_MINUS);
        end
        for (int i = chars.size() - 1; i >= 0; i--) begin
            tc.ch   = chars[i];
            tc.last = (i == 0);
            pending_text.push_back(tc);
        end
    endfunction

    function automatic logic [31:0] bid_word(input logic s, input logic [7:0] bexp,
                                             input logic [23:0] coeff);
        if (coeff[23]) begin
            return {s, 2'b11, bexp, coeff[20:0]};
        end
        return {s, bexp, coeff[22:0]};
    endfunction

    function automatic logic [31:0] dpd_word(input logic s, input logic [7:0] bexp,
                                             input logic [3:0] lead, input logic [19:0] declets);
        logic [4:0] g;
        g = lead[3] ? {2'b11, bexp[7:6], lead[0]} : {bexp[7:6], lead[2:0]};
        return {s, g, bexp[5:0], declets};
    endfunction

    function automatic logic [31:0] random_word(input logic enc);
        int unsigned pick;
        int unsigned digits;
        logic [7:0]  bexp;
        logic [23:0] coeff;
        logic [19:0] declets;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            return $urandom;
        end
        if (pick < 75) begin
            bexp = EXP_BIAS - 8'd10 + 8'($urandom_range(0, 16));
        end else if (enc == ENC_DPD) begin
            bexp = 8'($urandom_range(0, 191));
        end else begin
            bexp = 8'($urandom_range(0, 255));
        end
        if (enc == ENC_DPD) begin
            declets = 20'($urandom);
            return dpd_word(1'($urandom_range(0, 1)), bexp, 4'($urandom_range(0, 9)),
                            declets);
        end
        digits = $urandom_range(1, 7);
        coeff  = 24'($urandom_range(0, 10**digits - 1));
        if (pick >= 95) begin
            coeff = 24'($urandom);
        end
        return bid_word(1'($urandom_range(0, 1)), bexp, coeff);
    endfunction

    function automatic void add_word(input logic [31:0] w, input bit drain);
        word_item_t item;
        item.word  = w;
        item.drain = drain;
        word_queue.push_back(item);
    endfunction

    function automatic void queue_random(input logic enc, input int count);
        repeat (count) begin
            add_word(random_word(enc), $urandom_range(0, 19) == 0);
        end
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_IDX_ENCODING:  cur_encoding  = data[0];
            CFG_IDX_MAX_CHARS: cur_max_chars = data;
            default: ;
        endcase
    endtask

    task automatic configure(input logic enc, input logic [6:0] max_chars,
                             input int idle_pct, input int stall_pct);
        logic [5:0] pad;
        pad = 6'($urandom);
        write_reg(CFG_IDX_ENCODING, {pad, enc});
        write_reg(CFG_IDX_MAX_CHARS, max_chars);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    task automatic wait_drained();
        while (word_queue.size() > 0 || i_in_valid || pending_text.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // hold the next item back until the sender may present it
    always @(posedge i_clk) begin
        word_item_t head;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                render_text(i_word);
            end
            if (!i_in_valid || o_in_ready) begin
                if (word_queue.size() > 0 &&
                        !(word_queue[0].drain && pending_text.size() > 0) &&
                        $urandom_range(0, 99) >= send_idle_pct) begin
                    head = word_queue.pop_front();
                    i_in_valid <= 1'b1;
                    i_word     <= head.word;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        text_char_t want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_text.size() == 0) begin
                    $error("unexpected item: text_char %h last %b", o_text_char, o_last);
                    error_count++;
                end else begin
                    want = pending_text.pop_front();
                    if (o_text_char !== want.ch) begin
                        $error("text_char: expected %h, actual %h", want.ch, o_text_char);
                        error_count++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %b, actual %b", want.last, o_last);
                        error_count++;
                    end
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("decimal32_to_text_unit verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        add_word(32'h0000_0000, 1'b0);
        add_word(bid_word(1'b0, EXP_BIAS, 24'd1234567), 1'b0);
        add_word(bid_word(1'b1, EXP_BIAS - 8'd3, 24'd1234567), 1'b0);
        add_word(bid_word(1'b1, EXP_BIAS, 24'd0), 1'b0);
        add_word(bid_word(1'b0, EXP_BIAS + 8'd5, 24'd9999999), 1'b0);
        add_word(bid_word(1'b1, EXP_BIAS, 24'hFF_FFFF), 1'b0);
        add_word(bid_word(1'b0, 8'hFF, 24'd1), 1'b0);
        add_word(bid_word(1'b1, EXP_BIAS - 8'd10, 24'd5), 1'b0);
        add_word(32'hFFFF_FFFF, 1'b0);
        add_word(32'h7800_0000, 1'b0);
        add_word(32'h7C00_0000, 1'b1);
        queue_random(ENC_BID, 40);
        wait_drained();

        configure(ENC_DPD, 7'd64, 0, 0);
        add_word(dpd_word(1'b0, EXP_BIAS, 4'd9, 20'hF_FFFF), 1'b0);
        add_word(dpd_word(1'b1, EXP_BIAS - 8'd2, 4'd8, {10'h37E, 10'h0FF}), 1'b0);
        add_word(dpd_word(1'b1, 8'd0, 4'd0, 20'h0_0000), 1'b0);
        add_word(dpd_word(1'b0, 8'd191, 4'd7, {10'h16E, 10'h25A}), 1'b0);
        add_word(32'h7FFF_FFFF, 1'b0);
        add_word(dpd_word(1'b0, EXP_BIAS - 8'd7, 4'd1, {10'h0AB, 10'h3CD}), 1'b0);
        add_word(dpd_word(1'b1, EXP_BIAS + 8'd3, 4'd0, 20'h0_0005), 1'b1);
        queue_random(ENC_DPD, 40);
        wait_drained();

        configure(ENC_BID, 7'd127, 65, 0);
        queue_random(ENC_BID, 50);
        wait_drained();

        configure(ENC_DPD, 7'd1, 0, 65);
        queue_random(ENC_DPD, 40);
        wait_drained();

        configure(ENC_BID, 7'd0, 25, 25);
        queue_random(ENC_BID, 15);
        wait_drained();

        configure(ENC_DPD, 7'd100, 25, 25);
        write_reg(CFG_IDX_SPARE, 7'h55);
        queue_random(ENC_DPD, 40);
        wait_drained();

        configure(ENC_BID, 7'd12, 0, 65);
        queue_random(ENC_BID, 50);
        wait_drained();

        configure(ENC_DPD, 7'd5, 65, 0);
        queue_random(ENC_DPD, 50);
        wait_drained();

        configure(ENC_BID, 7'd64, 25, 25);
        queue_random(ENC_BID, 50);
        wait_drained();

        configure(ENC_DPD, 7'd20, 0, 0);
        queue_random(ENC_DPD, 50);
        wait_drained();

        if (error_count == 0) begin
            $display("decimal32_to_text_unit verification clean");
        end else begin
            $display("decimal32_to_text_unit verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/d32txt_pkg.sv
src/d32txt_ctrl.sv
src/d32txt_dp.sv
src/decimal32_to_text_unit.sv
bench/testbench.sv
